FILE: hdl/emn_pkg.sv
// Shared constants, types and codes for the entrywise matrix norm block.
package emn_pkg;

  // Entry and result widths
  localparam int ENTRY_W    = 32;
  localparam int VALUE_BITS = 32;
  localparam int SQ_W       = 2 * VALUE_BITS;
  localparam int NORM_W     = 48;
  localparam int ACC_W      = 64;
  localparam int ROOT_W     = ACC_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int STEP_W     = $clog2(ROOT_W);
  localparam int MODE_W     = 2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Norm mode codes
  localparam logic [MODE_W-1:0] MODE_L1    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_L2    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LINF  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_L2;

  // Largest value the result field can carry, in accumulator width
  localparam logic [ACC_W-1:0] NORM_MAX = {{(ACC_W - NORM_W){1'b0}}, {NORM_W{1'b1}}};

  // Classified request as it sits in the queue
  typedef struct packed {
    logic [VALUE_BITS-1:0] mag;
    logic [MODE_W-1:0]     mode;
    logic                  last;
  } emn_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } emn_q_sts_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_FIN,
    ST_ROOT
  } emn_state_t;

  typedef struct packed {
    logic start;
    logic take;
  } emn_root_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } emn_root_sts_t;

endpackage

FILE: hdl/emn_in_if.sv
// Input channel: matrix entries with a last mark.
interface emn_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [emn_pkg::ENTRY_W-1:0] entry_value;
  logic                               last_entry;

  modport source (output valid, output entry_value, output last_entry, input ready);
  modport sink   (input valid, input entry_value, input last_entry, output ready);
endinterface

FILE: hdl/emn_out_if.sv
// Result channel: one norm per matrix with its saturation flag.
interface emn_out_if;
  logic                        valid;
  logic                        ready;
  logic [emn_pkg::NORM_W-1:0]  norm_value;
  logic                        saturated;

  modport source (output valid, output norm_value, output saturated, input ready);
  modport sink   (input valid, input norm_value, input saturated, output ready);
endinterface

FILE: hdl/emn_front.sv
// Front end: holds the mode register, takes entries and classifies them for the queue.
module emn_front (
  input  logic                          clk,
  input  logic                          rst_n,
  emn_in_if.sink                        in_ch,
  input  logic                          cfg_we,
  input  logic [emn_pkg::MODE_W-1:0]    cfg_wdata,
  input  emn_pkg::emn_q_sts_t           q_sts,
  output logic                          q_push,
  output emn_pkg::emn_item_t            q_item
);

  logic [emn_pkg::MODE_W-1:0]     mode_r;
  logic [emn_pkg::VALUE_BITS-1:0] raw;
  logic [emn_pkg::VALUE_BITS-1:0] mag;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= emn_pkg::MODE_RESET;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Take the magnitude of the low bits; the most negative value maps to itself
  always_comb begin
    raw = in_ch.entry_value[emn_pkg::VALUE_BITS-1:0];
    if (raw[emn_pkg::VALUE_BITS-1]) begin
      mag = ~raw + {{(emn_pkg::VALUE_BITS-1){1'b0}}, 1'b1};
    end else begin
      mag = raw;
    end
  end

  // Accept a request whenever the queue has room
  assign in_ch.ready  = !q_sts.full;
  assign q_push       = in_ch.valid && !q_sts.full;
  assign q_item.mag   = mag;
  assign q_item.mode  = mode_r;
  assign q_item.last  = in_ch.last_entry;

endmodule

FILE: hdl/emn_fifo.sv
// Short queue of classified requests between front and back.
module emn_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  emn_pkg::emn_item_t   wr_item,
  input  logic                 pop,
  output emn_pkg::emn_item_t   rd_item,
  output emn_pkg::emn_q_sts_t  sts
);

  emn_pkg::emn_item_t          mem_r [emn_pkg::QUEUE_DEPTH];
  logic [emn_pkg::QPTR_W-1:0]  wr_ptr_r;
  logic [emn_pkg::QPTR_W-1:0]  rd_ptr_r;
  logic [emn_pkg::QCNT_W-1:0]  cnt_r;

  function automatic logic [emn_pkg::QPTR_W-1:0] ptr_inc(input logic [emn_pkg::QPTR_W-1:0] p);
    if (p == emn_pkg::QPTR_W'(emn_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + emn_pkg::QPTR_W'(1);
  endfunction

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + emn_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - emn_pkg::QCNT_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item   = mem_r[rd_ptr_r];
  assign sts.full  = (cnt_r == emn_pkg::QCNT_W'(emn_pkg::QUEUE_DEPTH));
  assign sts.empty = (cnt_r == '0);

endmodule

FILE: hdl/emn_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
module emn_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  emn_pkg::emn_root_ctl_t      ctl,
  input  logic [emn_pkg::ACC_W-1:0]   radicand,
  output emn_pkg::emn_root_sts_t      sts,
  output logic [emn_pkg::ROOT_W-1:0]  root
);

  logic                         busy_r;
  logic                         done_r;
  logic [emn_pkg::STEP_W-1:0]   step_r;
  logic [emn_pkg::ACC_W-1:0]    x_r;
  logic [emn_pkg::REM_W-1:0]    rem_r;
  logic [emn_pkg::ROOT_W-1:0]   root_r;
  logic [emn_pkg::REM_W-1:0]    rem_sh;
  logic [emn_pkg::REM_W-1:0]    trial;
  logic                         fits;

  // Bring down two bits and try the next root digit
  always_comb begin
    rem_sh = {rem_r[emn_pkg::REM_W-3:0], x_r[emn_pkg::ACC_W-1 -: 2]};
    trial  = emn_pkg::REM_W'({root_r, 2'b01});
    fits   = (rem_sh >= trial);
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (ctl.start && !busy_r && !done_r) begin
      busy_r <= 1'b1;
      step_r <= emn_pkg::STEP_W'(emn_pkg::ROOT_W - 1);
    end else if (busy_r) begin
      step_r <= step_r - emn_pkg::STEP_W'(1);
      if (step_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else if (ctl.take) begin
      done_r <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctl.start && !busy_r && !done_r) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r <= {x_r[emn_pkg::ACC_W-3:0], 2'b00};
      if (fits) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[emn_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[emn_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = root_r;

endmodule

FILE: hdl/emn_back.sv
// Back end: squares, accumulates with saturation or keeps the maximum, and delivers the norm per matrix.
module emn_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  emn_pkg::emn_item_t   q_item,
  input  emn_pkg::emn_q_sts_t  q_sts,
  output logic                 q_pop,
  emn_out_if.source            out_ch
);

  emn_pkg::emn_state_t            state_r, state_nxt;
  logic                           s1_valid_r, s1_valid_nxt;
  emn_pkg::emn_item_t             s1_item_r;
  logic [emn_pkg::SQ_W-1:0]       s1_sq_r;
  logic [emn_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [emn_pkg::MODE_W-1:0]     fin_mode_r, fin_mode_nxt;
  logic                           sat_hold_r, sat_hold_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [emn_pkg::NORM_W-1:0]     out_norm_r, out_norm_nxt;
  logic                           out_sat_r, out_sat_nxt;

  logic                           s1_adv;
  logic                           out_free;
  logic [emn_pkg::ACC_W-1:0]      mag_ext;
  logic [emn_pkg::ACC_W-1:0]      addend;
  logic [emn_pkg::ACC_W:0]        sum;
  logic [emn_pkg::ACC_W-1:0]      fold_acc;
  logic                           fold_ovf;
  emn_pkg::emn_root_ctl_t         root_ctl;
  emn_pkg::emn_root_sts_t         root_sts;
  logic [emn_pkg::ROOT_W-1:0]     root;

  function automatic logic is_l2(input logic [emn_pkg::MODE_W-1:0] m);
    return (m == emn_pkg::MODE_L2) || (m == emn_pkg::MODE_SPARE);
  endfunction

  emn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (root_ctl),
    .radicand (acc_r),
    .sts      (root_sts),
    .root     (root)
  );

  // Pop into the square stage whenever it is empty or the accumulate stage will take its contents
  assign s1_adv   = !s1_valid_r || (state_r == emn_pkg::ST_ACC);
  assign q_pop    = !q_sts.empty && s1_adv;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (q_pop) begin
      s1_valid_nxt = 1'b1;
    end else if (state_r == emn_pkg::ST_ACC) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // Fold one entry into the accumulator as its mode says
  always_comb begin
    mag_ext  = emn_pkg::ACC_W'(s1_item_r.mag);
    addend   = (s1_item_r.mode == emn_pkg::MODE_L1) ? mag_ext : emn_pkg::ACC_W'(s1_sq_r);
    sum      = {1'b0, acc_r} + {1'b0, addend};
    fold_acc = acc_r;
    fold_ovf = ovf_r;
    case (s1_item_r.mode)
      emn_pkg::MODE_L1: begin
        if ((acc_r > emn_pkg::NORM_MAX) || (sum > {1'b0, emn_pkg::NORM_MAX})) begin
          fold_acc = emn_pkg::NORM_MAX;
          fold_ovf = 1'b1;
        end else begin
          fold_acc = sum[emn_pkg::ACC_W-1:0];
        end
      end
      emn_pkg::MODE_LINF: begin
        if (mag_ext > acc_r) begin
          fold_acc = mag_ext;
        end
      end
      default: begin
        if (sum[emn_pkg::ACC_W]) begin
          fold_acc = '1;
          fold_ovf = 1'b1;
        end else begin
          fold_acc = sum[emn_pkg::ACC_W-1:0];
        end
      end
    endcase
  end

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    fin_mode_nxt  = fin_mode_r;
    sat_hold_nxt  = sat_hold_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_norm_nxt  = out_norm_r;
    out_sat_nxt   = out_sat_r;
    root_ctl      = '0;
    unique case (state_r)
      emn_pkg::ST_ACC: begin
        if (s1_valid_r) begin
          acc_nxt = fold_acc;
          ovf_nxt = fold_ovf;
          if (s1_item_r.last) begin
            fin_mode_nxt = s1_item_r.mode;
            state_nxt    = emn_pkg::ST_FIN;
          end
        end
      end
      emn_pkg::ST_FIN: begin
        if (is_l2(fin_mode_r)) begin
          root_ctl.start = 1'b1;
          sat_hold_nxt   = ovf_r;
          acc_nxt        = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = emn_pkg::ST_ROOT;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          if (acc_r > emn_pkg::NORM_MAX) begin
            out_norm_nxt = '1;
            out_sat_nxt  = 1'b1;
          end else begin
            out_norm_nxt = acc_r[emn_pkg::NORM_W-1:0];
            out_sat_nxt  = ovf_r;
          end
          acc_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = emn_pkg::ST_ACC;
        end
      end
      emn_pkg::ST_ROOT: begin
        if (root_sts.done && out_free) begin
          root_ctl.take = 1'b1;
          out_valid_nxt = 1'b1;
          out_norm_nxt  = emn_pkg::NORM_W'(root);
          out_sat_nxt   = sat_hold_r;
          state_nxt     = emn_pkg::ST_ACC;
        end
      end
      default: begin
        state_nxt = emn_pkg::ST_ACC;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= emn_pkg::ST_ACC;
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_item_r <= q_item;
      s1_sq_r   <= q_item.mag * q_item.mag;
    end
    fin_mode_r <= fin_mode_nxt;
    sat_hold_r <= sat_hold_nxt;
    out_norm_r <= out_norm_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.norm_value = out_norm_r;
  assign out_ch.saturated  = out_sat_r;

endmodule

FILE: hdl/entrywise_matrix_norm.sv
// Top level of the entrywise matrix norm block: front, queue and back.
//
//   channel   direction  payload                       handshake
//   in_chan   in         entry_value[31:0], last_entry valid / ready
//   out_chan  out        norm_value[47:0], saturated   valid / ready
//   cfg_*     in         cfg_wdata[1:0] (norm mode)    cfg_we, no wait
//
// One entry per cycle while accumulating: the square stage and the accumulate
// stage are registered and the four-deep queue absorbs back-end pauses.
// Each matrix ends in a finishing state in L1 and L-infinity; in L2 the back end
// starts the root unit, runs 32 root steps (two radicand bits a cycle), then collects.
// Reset is synchronous and active low; the accumulator starts at zero and
// the mode at L2. A stalled result holds in the output register.
module entrywise_matrix_norm (
  input  logic                        clk,
  input  logic                        rst_n,
  emn_in_if.sink                      in_chan,
  emn_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [emn_pkg::MODE_W-1:0]  cfg_wdata
);

  logic                 q_push;
  logic                 q_pop;
  emn_pkg::emn_item_t   q_wr_item;
  emn_pkg::emn_item_t   q_rd_item;
  emn_pkg::emn_q_sts_t  q_sts;

  emn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_sts     (q_sts),
    .q_push    (q_push),
    .q_item    (q_wr_item)
  );

  emn_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .sts     (q_sts)
  );

  emn_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_item (q_rd_item),
    .q_sts  (q_sts),
    .q_pop  (q_pop),
    .out_ch (out_chan)
  );

  // Never write a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_sts.full)
    else $error("request pushed into a full queue");

  // Never read an empty queue
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_sts.empty)
    else $error("request popped from an empty queue");

  // Back-pressure on the input only comes from a full queue
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && !in_chan.ready) |-> q_sts.full)
    else $error("input stalled while the queue has room");

  // No result straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid after reset");

endmodule

FILE: tb/entrywise_matrix_norm_tb.sv
// Self-checking testbench for the entrywise matrix norm block.
module entrywise_matrix_norm_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT       = 30;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 100;

  typedef struct packed {
    logic [emn_pkg::NORM_W-1:0] norm;
    logic                       sat;
  } norm_result_t;

  // Running norm of the current matrix and the norms still owed by the block
  class norm_predictor;
    logic [emn_pkg::MODE_W-1:0] mode;
    logic [emn_pkg::ACC_W-1:0]  acc;
    logic                       ovf;
    norm_result_t               expected_norms[$];
    int                         errors;

    function new();
      mode   = emn_pkg::MODE_RESET;
      acc    = '0;
      ovf    = 1'b0;
      errors = 0;
    endfunction

    function automatic logic [emn_pkg::ACC_W-1:0] entry_mag(
      logic [emn_pkg::ENTRY_W-1:0] v);
      logic [emn_pkg::VALUE_BITS-1:0] low;
      low = v[emn_pkg::VALUE_BITS-1:0];
      // The most negative value maps onto its own bit pattern, 2^31
      if (low[emn_pkg::VALUE_BITS-1]) low = ~low + 1'b1;
      return {{(emn_pkg::ACC_W - emn_pkg::VALUE_BITS){1'b0}}, low};
    endfunction

    function automatic logic [emn_pkg::ACC_W-1:0] floor_root(
      logic [emn_pkg::ACC_W-1:0] x);
      logic [emn_pkg::ACC_W-1:0] root;
      logic [emn_pkg::ACC_W-1:0] trial;
      root = '0;
      // Build the root one bit at a time, keeping each bit whose square still fits
      for (int b = emn_pkg::ROOT_W - 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    function void note_entry(logic [emn_pkg::ENTRY_W-1:0] v, logic last);
      logic [emn_pkg::ACC_W-1:0] a;
      logic [emn_pkg::ACC_W-1:0] sq;
      logic [emn_pkg::ACC_W-1:0] norm;
      logic                      sat;
      norm_result_t              res;
      a = entry_mag(v);
      // Fold the entry in as the mode at this request says
      case (mode)
        emn_pkg::MODE_L1: begin
          if (acc > emn_pkg::NORM_MAX || a > emn_pkg::NORM_MAX - acc) begin
            acc = emn_pkg::NORM_MAX;
            ovf = 1'b1;
          end else begin
            acc = acc + a;
          end
        end
        emn_pkg::MODE_LINF: begin
          if (a > acc) acc = a;
        end
        default: begin
          sq = a * a;
          if (sq > ~acc) begin
            acc = '1;
            ovf = 1'b1;
          end else begin
            acc = acc + sq;
          end
        end
      endcase
      if (!last) return;
      // Read out as the mode at the last entry says, then clear
      sat = ovf;
      if (mode == emn_pkg::MODE_L1 || mode == emn_pkg::MODE_LINF) begin
        norm = acc;
        if (norm > emn_pkg::NORM_MAX) begin
          norm = emn_pkg::NORM_MAX;
          sat  = 1'b1;
        end
      end else begin
        norm = floor_root(acc);
      end
      res.norm = norm[emn_pkg::NORM_W-1:0];
      res.sat  = sat;
      expected_norms.push_back(res);
      acc = '0;
      ovf = 1'b0;
    endfunction

    function void check_norm(logic [emn_pkg::NORM_W-1:0] norm, logic sat);
      norm_result_t res;
      if (expected_norms.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual norm %h sat %b",
                 $time, norm, sat);
        errors++;
        return;
      end
      res = expected_norms.pop_front();
      if (res.norm !== norm) begin
        $display("%0t: norm_value mismatch, expected %h, actual %h", $time, res.norm, norm);
        errors++;
      end
      if (res.sat !== sat) begin
        $display("%0t: saturated mismatch, expected %b, actual %b", $time, res.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [emn_pkg::MODE_W-1:0] cfg_wdata;
  logic                       no_idle;
  int                         cycle_count;
  int                         result_count;
  norm_predictor              norms;

  emn_in_if  in_chan ();
  emn_out_if out_chan ();

  entrywise_matrix_norm dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Give up on a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL entrywise_matrix_norm");
      $finish;
    end
  end

  // Offer one entry request, idling first for a random gap
  task automatic send_entry(input logic [emn_pkg::ENTRY_W-1:0] v, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.entry_value <= v;
    in_chan.last_entry  <= last;
    do @(posedge clk); while (!in_chan.ready);
    norms.note_entry(v, last);
  endtask

  // Drain, let the pipeline settle, then write the mode register
  task automatic set_mode(input logic [emn_pkg::MODE_W-1:0] m);
    in_chan.valid <= 1'b0;
    while (norms.expected_norms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    norms.mode = m;
  endtask

  function automatic logic [emn_pkg::ENTRY_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      1:       return $urandom_range(0, 511) - 256;
      2:       return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Accept results with random pauses and one long hold-off
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    result_count = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (result_count == HOLD_AT) gap = HOLD_CYCLES;
      else gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      norms.check_norm(out_chan.norm_value, out_chan.saturated);
      result_count++;
    end
  end

  // Reset, directed cases, random phases, drain and verdict
  initial begin
    int len;
    int count;
    int mid;
    norms = new();
    no_idle = 1'b0;
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= emn_pkg::MODE_RESET;
    in_chan.valid       <= 1'b0;
    in_chan.entry_value <= '0;
    in_chan.last_entry  <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // L2 from reset: single most negative entry, then a saturating sum
    send_entry(32'h8000_0000, 1'b1);
    repeat (3) send_entry(32'h8000_0000, 1'b0);
    send_entry(32'h8000_0000, 1'b1);

    // L1 over the extremes, then an all-zero matrix
    set_mode(emn_pkg::MODE_L1);
    send_entry(32'h7fff_ffff, 1'b0);
    send_entry(32'hffff_ffff, 1'b0);
    send_entry(32'h8000_0000, 1'b1);
    send_entry(32'h0000_0000, 1'b1);

    // L-infinity
    set_mode(emn_pkg::MODE_LINF);
    send_entry(32'h0000_0001, 1'b0);
    send_entry(32'h8000_0000, 1'b0);
    send_entry(32'h7fff_ffff, 1'b1);
    send_entry(32'hffff_ffff, 1'b1);

    // Spare mode behaves as L2
    set_mode(emn_pkg::MODE_SPARE);
    send_entry(32'h0000_0003, 1'b0);
    send_entry(32'hffff_fffd, 1'b1);

    // Squares carried into L1: the sum is already beyond the field and clamps
    set_mode(emn_pkg::MODE_L2);
    send_entry(32'h8000_0000, 1'b0);
    send_entry(32'h8000_0000, 1'b0);
    set_mode(emn_pkg::MODE_L1);
    send_entry(32'h0000_0005, 1'b1);

    // Squares carried into L-infinity: oversized result clamps
    set_mode(emn_pkg::MODE_L2);
    send_entry(32'h4000_0000, 1'b0);
    set_mode(emn_pkg::MODE_LINF);
    send_entry(32'h0000_0007, 1'b1);

    // Absolutes carried into L2
    set_mode(emn_pkg::MODE_L1);
    send_entry(32'h0001_2345, 1'b0);
    set_mode(emn_pkg::MODE_L2);
    send_entry(32'h0000_0100, 1'b1);

    // Random phases, each under its own mode, some with a mode change mid-matrix
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_mode(emn_pkg::MODE_W'($urandom_range(0, 3)));
      no_idle = ($urandom_range(0, 3) == 0);
      count = 0;
      while (count < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        mid = ($urandom_range(0, 7) == 0) ? $urandom_range(1, len) : 0;
        for (int k = 0; k < len; k++) begin
          if (mid != 0 && k == mid) set_mode(emn_pkg::MODE_W'($urandom_range(0, 3)));
          send_entry(pick_value(), k == len - 1);
          count++;
        end
      end
    end

    // Drop valid, drain the results and watch for strays
    in_chan.valid <= 1'b0;
    while (norms.expected_norms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (norms.errors == 0 && norms.expected_norms.size() == 0) begin
      $display("PASS entrywise_matrix_norm");
    end else begin
      $display("FAIL entrywise_matrix_norm");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/emn_pkg.sv
hdl/emn_in_if.sv
hdl/emn_out_if.sv
hdl/emn_front.sv
hdl/emn_fifo.sv
hdl/emn_sqrt.sv
hdl/emn_back.sv
hdl/entrywise_matrix_norm.sv
tb/entrywise_matrix_norm_tb.sv
